// File: sv/rpp_pkg.sv
`default_nettype none
package rpp_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int ATAN_ENTRIES      = 24;

  localparam int ANGLE_W = 15;
  localparam logic [ANGLE_W-1:0] ANGLE_TURN = 15'd23040;

  // phase = a*186413 + floor(a*23/45), which is floor(a * 2^32 / 23040)
  localparam int PHASE_W = 32;
  localparam logic [PHASE_W-1:0] PHASE_INT = 32'd186413;
  localparam int T_W = 20;
  localparam logic [T_W-1:0] PHASE_NUM = 20'd23;
  localparam int RECIP_W = 27;
  localparam logic [RECIP_W-1:0] RECIP_45 = 27'd95443718;
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W = T_W + RECIP_W;
  localparam int Q_W = PROD_W - RECIP_SHIFT;

  localparam int CORDIC_W  = 32;
  localparam int Z_W       = 33;
  localparam int FRAC_BITS = 29;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd326016437;

  typedef struct packed {
    logic valid;
    logic flip;
  } rpp_ctl_t;

  function automatic logic signed [Z_W-1:0] atan_phase(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = 33'sd536870912;
      1:       v = 33'sd316933406;
      2:       v = 33'sd167458907;
      3:       v = 33'sd85004756;
      4:       v = 33'sd42667331;
      5:       v = 33'sd21354465;
      6:       v = 33'sd10679838;
      7:       v = 33'sd5340245;
      8:       v = 33'sd2670163;
      9:       v = 33'sd1335087;
      10:      v = 33'sd667544;
      11:      v = 33'sd333772;
      12:      v = 33'sd166886;
      13:      v = 33'sd83443;
      14:      v = 33'sd41722;
      15:      v = 33'sd20861;
      16:      v = 33'sd10430;
      17:      v = 33'sd5215;
      18:      v = 33'sd2608;
      19:      v = 33'sd1304;
      20:      v = 33'sd652;
      21:      v = 33'sd326;
      22:      v = 33'sd163;
      23:      v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: sv/rpp_if.sv
`default_nettype none
interface rpp_in_if import rpp_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] pivot_x;
  logic signed [COORD_WIDTH-1:0] pivot_y;
  logic        [ANGLE_W-1:0]     angle;

  modport source(output valid, point_x, point_y, pivot_x, pivot_y, angle, input ready);
  modport sink(input valid, point_x, point_y, pivot_x, pivot_y, angle, output ready);
endinterface

interface rpp_out_if import rpp_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic                          saturated;

  modport source(output valid, out_x, out_y, saturated, input ready);
  modport sink(input valid, out_x, out_y, saturated, output ready);
endinterface
`default_nettype wire

// File: sv/rotate_point_about_pivot_top.sv
// Rotates a point about a pivot by an angle given in 1/64 degree.
// Channels: request carries point_x, point_y, pivot_x, pivot_y (signed Q15.8)
// and angle (0..23039, larger codes wrap once); result carries out_x, out_y
// and saturated, set when either coordinate was clipped to range.
// Both channels move a request at a clock edge where valid and ready are high.
// Throughput: one request per cycle while the skid stage is empty.
// A request passes from acceptance to result valid through the phase
// registers, the register of each CORDIC cell, the product and rounded-sum
// registers, and the output register.
// Every cell of the CORDIC chain advances once a cycle while the skid stage
// is empty, so the rate is set by that shared advance of the whole chain.
// When the receiver stalls, the result waits in the output register and the
// next one lands in the skid stage; request.ready drops only while the skid
// stage is full and rises again the cycle after the receiver takes a result.
// Reset clears all valid flags, including those of the output and skid stages,
// but not their data; nothing else is held between requests.
`default_nettype none
module rotate_point_about_pivot_top import rpp_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  rpp_in_if.sink   request,
  rpp_out_if.source result
);

  localparam int N = CORDIC_STAGES;

  logic run;

  rpp_ctl_t                      ctl [0:N];
  logic signed [CORDIC_W-1:0]    cx_ [0:N];
  logic signed [CORDIC_W-1:0]    cy_ [0:N];
  logic signed [Z_W-1:0]         cz  [0:N];
  logic signed [COORD_WIDTH:0]   cdx [0:N];
  logic signed [COORD_WIDTH:0]   cdy [0:N];
  logic signed [COORD_WIDTH-1:0] ccx [0:N];
  logic signed [COORD_WIDTH-1:0] ccy [0:N];

  logic                          fin_valid;
  logic signed [COORD_WIDTH-1:0] fin_x, fin_y;
  logic                          fin_sat;

  logic                          out_valid;
  logic signed [COORD_WIDTH-1:0] out_x, out_y;
  logic                          out_sat;
  logic                          skid_valid;
  logic signed [COORD_WIDTH-1:0] skid_x, skid_y;
  logic                          skid_sat;

  assign run           = !skid_valid;
  assign request.ready = run;

  rpp_phase #(.COORD_WIDTH(COORD_WIDTH)) u_phase (
    .clk     (clk),
    .rst     (rst),
    .run     (run),
    .valid   (request.valid),
    .point_x (request.point_x),
    .point_y (request.point_y),
    .pivot_x (request.pivot_x),
    .pivot_y (request.pivot_y),
    .angle   (request.angle),
    .ctl     (ctl[0]),
    .z       (cz[0]),
    .dx      (cdx[0]),
    .dy      (cdy[0]),
    .cx      (ccx[0]),
    .cy      (ccy[0])
  );

  assign cx_[0] = CORDIC_GAIN;
  assign cy_[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rpp_cell #(.STAGE(i), .COORD_WIDTH(COORD_WIDTH)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .run    (run),
      .up_ctl (ctl[i]),
      .up_x   (cx_[i]),
      .up_y   (cy_[i]),
      .up_z   (cz[i]),
      .up_dx  (cdx[i]),
      .up_dy  (cdy[i]),
      .up_cx  (ccx[i]),
      .up_cy  (ccy[i]),
      .dn_ctl (ctl[i+1]),
      .dn_x   (cx_[i+1]),
      .dn_y   (cy_[i+1]),
      .dn_z   (cz[i+1]),
      .dn_dx  (cdx[i+1]),
      .dn_dy  (cdy[i+1]),
      .dn_cx  (ccx[i+1]),
      .dn_cy  (ccy[i+1])
    );
  end

  rpp_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .run       (run),
    .ctl       (ctl[N]),
    .x         (cx_[N]),
    .y         (cy_[N]),
    .dx        (cdx[N]),
    .dy        (cdy[N]),
    .cx        (ccx[N]),
    .cy        (ccy[N]),
    .valid     (fin_valid),
    .out_x     (fin_x),
    .out_y     (fin_y),
    .saturated (fin_sat)
  );

  // the residual angle z of the last cell is not needed
  logic unused_z;
  assign unused_z = ^cz[N];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (fin_valid) begin
      if (!out_valid || result.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result.ready) begin
        out_x   <= skid_x;
        out_y   <= skid_y;
        out_sat <= skid_sat;
      end
    end else if (fin_valid) begin
      if (!out_valid || result.ready) begin
        out_x   <= fin_x;
        out_y   <= fin_y;
        out_sat <= fin_sat;
      end else begin
        skid_x   <= fin_x;
        skid_y   <= fin_y;
        skid_sat <= fin_sat;
      end
    end
  end

  assign result.valid     = out_valid;
  assign result.out_x     = out_x;
  assign result.out_y     = out_y;
  assign result.saturated = out_sat;

  localparam logic signed [COORD_WIDTH-1:0] HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !result.ready && fin_valid))
    else $error("skid stage filled without a stalled result");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && result.ready |=> !skid_valid && out_valid)
    else $error("skid stage did not drain into output register");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |->
      (result.out_x == HI || result.out_x == LO ||
       result.out_y == HI || result.out_y == LO))
    else $error("saturated flag set but no coordinate at a bound");

endmodule
`default_nettype wire

// File: sv/rpp_phase.sv
`default_nettype none
module rpp_phase import rpp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          run,
  input  logic                          valid,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] pivot_x,
  input  logic signed [COORD_WIDTH-1:0] pivot_y,
  input  logic        [ANGLE_W-1:0]     angle,
  output rpp_ctl_t                      ctl,
  output logic signed [Z_W-1:0]         z,
  output logic signed [COORD_WIDTH:0]   dx,
  output logic signed [COORD_WIDTH:0]   dy,
  output logic signed [COORD_WIDTH-1:0] cx,
  output logic signed [COORD_WIDTH-1:0] cy
);

  logic [2:0] vld;

  logic [ANGLE_W-1:0]            wrapped;
  logic [PHASE_W-1:0]            lin1, lin2;
  logic [T_W-1:0]                t1;
  logic [PROD_W-1:0]             prod;
  logic [Q_W-1:0]                q2;
  logic signed [COORD_WIDTH:0]   dx1, dy1, dx2, dy2;
  logic signed [COORD_WIDTH-1:0] cx1, cy1, cx2, cy2;
  logic [PHASE_W-1:0]            phase;
  logic                          flip;
  logic                          flip_q;
  logic [PHASE_W-1:0]            folded;

  assign wrapped = (angle >= ANGLE_TURN) ? angle - ANGLE_TURN : angle;
  assign prod    = PROD_W'(t1) * PROD_W'(RECIP_45);
  assign phase   = lin2 + PHASE_W'(q2);
  // fold into the right half-plane; cos and sin are negated after the chain
  assign flip    = phase[PHASE_W-1] ^ phase[PHASE_W-2];
  assign folded  = {phase[PHASE_W-1] ^ flip, phase[PHASE_W-2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (run) begin
      vld <= {vld[1:0], valid};
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      lin1 <= PHASE_W'(wrapped) * PHASE_INT;
      t1   <= T_W'(wrapped) * PHASE_NUM;
      dx1  <= (COORD_WIDTH+1)'(point_x) - (COORD_WIDTH+1)'(pivot_x);
      dy1  <= (COORD_WIDTH+1)'(point_y) - (COORD_WIDTH+1)'(pivot_y);
      cx1  <= pivot_x;
      cy1  <= pivot_y;

      lin2 <= lin1;
      q2   <= prod[PROD_W-1:RECIP_SHIFT];
      dx2  <= dx1;
      dy2  <= dy1;
      cx2  <= cx1;
      cy2  <= cy1;

      flip_q <= flip;
      z      <= Z_W'($signed(folded));
      dx     <= dx2;
      dy     <= dy2;
      cx     <= cx2;
      cy     <= cy2;
    end
  end

  assign ctl = {vld[2], flip_q};

endmodule
`default_nettype wire

// File: sv/rpp_cell.sv
`default_nettype none
module rpp_cell import rpp_pkg::*; #(
  parameter int STAGE       = 0,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          run,
  input  rpp_ctl_t                      up_ctl,
  input  logic signed [CORDIC_W-1:0]    up_x,
  input  logic signed [CORDIC_W-1:0]    up_y,
  input  logic signed [Z_W-1:0]         up_z,
  input  logic signed [COORD_WIDTH:0]   up_dx,
  input  logic signed [COORD_WIDTH:0]   up_dy,
  input  logic signed [COORD_WIDTH-1:0] up_cx,
  input  logic signed [COORD_WIDTH-1:0] up_cy,
  output rpp_ctl_t                      dn_ctl,
  output logic signed [CORDIC_W-1:0]    dn_x,
  output logic signed [CORDIC_W-1:0]    dn_y,
  output logic signed [Z_W-1:0]         dn_z,
  output logic signed [COORD_WIDTH:0]   dn_dx,
  output logic signed [COORD_WIDTH:0]   dn_dy,
  output logic signed [COORD_WIDTH-1:0] dn_cx,
  output logic signed [COORD_WIDTH-1:0] dn_cy
);

  localparam logic signed [Z_W-1:0] ATAN = atan_phase(STAGE);

  logic signed [CORDIC_W-1:0] xs, ys;
  logic                       pos;

  assign xs  = up_x >>> STAGE;
  assign ys  = up_y >>> STAGE;
  assign pos = !up_z[Z_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_ctl <= '0;
    end else if (run) begin
      dn_ctl <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      dn_x  <= pos ? up_x - ys : up_x + ys;
      dn_y  <= pos ? up_y + xs : up_y - xs;
      dn_z  <= pos ? up_z - ATAN : up_z + ATAN;
      dn_dx <= up_dx;
      dn_dy <= up_dy;
      dn_cx <= up_cx;
      dn_cy <= up_cy;
    end
  end

endmodule
`default_nettype wire

// File: sv/rpp_rotate.sv
`default_nettype none
module rpp_rotate import rpp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          run,
  input  rpp_ctl_t                      ctl,
  input  logic signed [CORDIC_W-1:0]    x,
  input  logic signed [CORDIC_W-1:0]    y,
  input  logic signed [COORD_WIDTH:0]   dx,
  input  logic signed [COORD_WIDTH:0]   dy,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  output logic                          valid,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic                          saturated
);

  localparam int PW = CORDIC_W + COORD_WIDTH + 1;
  localparam int SW = PW + 1;
  localparam int VW = SW - FRAC_BITS + 1;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [COORD_WIDTH-1:0] HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic [1:0] vld;

  logic signed [CORDIC_W-1:0] c, s;
  logic signed [PW-1:0]       pcx, psy, pcy, psx;
  logic signed [COORD_WIDTH-1:0] cx1, cy1;
  logic signed [SW-1:0]       ax, ay;
  logic signed [VW-1:0]       vx, vy;
  logic                       ovx, ovy;

  assign c = ctl.flip ? -x : x;
  assign s = ctl.flip ? -y : y;

  assign ax = SW'(pcx) + SW'(psy) + HALF;
  assign ay = SW'(pcy) - SW'(psx) + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (run) begin
      vld <= {vld[0], ctl.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      pcx <= PW'(c) * PW'(dx);
      psy <= PW'(s) * PW'(dy);
      pcy <= PW'(c) * PW'(dy);
      psx <= PW'(s) * PW'(dx);
      cx1 <= cx;
      cy1 <= cy;

      vx <= VW'($signed(ax[SW-1:FRAC_BITS])) + VW'(cx1);
      vy <= VW'($signed(ay[SW-1:FRAC_BITS])) + VW'(cy1);
    end
  end

  // out of range unless every bit above the sign position agrees
  assign ovx = !((&vx[VW-1:COORD_WIDTH-1]) || !(|vx[VW-1:COORD_WIDTH-1]));
  assign ovy = !((&vy[VW-1:COORD_WIDTH-1]) || !(|vy[VW-1:COORD_WIDTH-1]));

  assign valid     = vld[1];
  assign out_x     = ovx ? (vx[VW-1] ? LO : HI) : vx[COORD_WIDTH-1:0];
  assign out_y     = ovy ? (vy[VW-1] ? LO : HI) : vy[COORD_WIDTH-1:0];
  assign saturated = ovx | ovy;

endmodule
`default_nettype wire
